[hdl/lsc_pkg.sv]
// Shared types, constants and control bundles of the line sensor qualifier.
package lsc_pkg;

  localparam int unsigned AdcBits   = 12;
  localparam int unsigned CountBits = 10;
  localparam int unsigned NumCh     = 4;
  localparam int unsigned DarkCntW  = $clog2(NumCh + 1);

  localparam logic [2:0] MinDarkReset = 3'd2;

  typedef enum logic [2:0] {
    KIND_WHITE  = 3'd0,
    KIND_BLACK  = 3'd1,
    KIND_FINISH = 3'd2,
    KIND_DETECT = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [AdcBits-1:0] sample_ch0;
    logic [AdcBits-1:0] sample_ch1;
    logic [AdcBits-1:0] sample_ch2;
    logic [AdcBits-1:0] sample_ch3;
  } in_item_t;

  typedef struct packed {
    logic [NumCh-1:0]    dark_mask;
    logic [DarkCntW-1:0] dark_count;
    logic                stop_flag;
    logic                is_calibrated;
    logic                calib_error;
    logic [AdcBits-1:0]  level_ch0;
    logic [AdcBits-1:0]  level_ch1;
    logic [AdcBits-1:0]  level_ch2;
    logic [AdcBits-1:0]  level_ch3;
  } out_item_t;

  typedef struct packed {
    logic acc_white;
    logic acc_black;
    logic mul;
    logic load;
    logic div_step;
    logic commit;
  } lane_ctrl_t;

  typedef struct packed {
    logic detect;
    logic clear;
    logic cal_set;
    logic emit;
    logic err;
  } merge_ctrl_t;

endpackage

[hdl/lsc_lane.sv]
// One channel lane: calibration sums, threshold divider and dark compare.
module lsc_lane #(
  parameter int unsigned COUNT_BITS = lsc_pkg::CountBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lsc_pkg::lane_ctrl_t                   ctrl_i,
  input  logic [lsc_pkg::AdcBits-1:0]           sample_i,
  input  logic [COUNT_BITS-1:0]                 wcnt_i,
  input  logic [COUNT_BITS-1:0]                 bcnt_i,
  input  logic [2*COUNT_BITS+lsc_pkg::AdcBits-1:0] den_sh_i,
  output logic                                  dark_o,
  output logic [lsc_pkg::AdcBits-1:0]           level_o
);
  import lsc_pkg::*;

  localparam int unsigned SumW  = AdcBits + COUNT_BITS;
  localparam int unsigned ProdW = SumW + COUNT_BITS;
  localparam int unsigned NumW  = ProdW + 1;

  logic [SumW-1:0]    sum_w_q, sum_w_d;
  logic [SumW-1:0]    sum_b_q, sum_b_d;
  logic [AdcBits-1:0] level_q, level_d;
  logic [ProdW-1:0]   prod_w_q, prod_w_d;
  logic [ProdW-1:0]   prod_b_q, prod_b_d;
  logic [NumW-1:0]    rem_q, rem_d;
  logic [AdcBits-1:0] quo_q, quo_d;
  logic [NumW-1:0]    den_ext;
  logic               rem_ge;

  assign den_ext = NumW'(den_sh_i);
  assign rem_ge  = (rem_q >= den_ext);

  always_comb begin
    sum_w_d  = sum_w_q;
    sum_b_d  = sum_b_q;
    level_d  = level_q;
    prod_w_d = prod_w_q;
    prod_b_d = prod_b_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    if (ctrl_i.acc_white) begin
      sum_w_d = sum_w_q + SumW'(sample_i);
    end
    if (ctrl_i.acc_black) begin
      sum_b_d = sum_b_q + SumW'(sample_i);
    end
    // Cross products of the midpoint numerator; the halving sits in the divisor.
    if (ctrl_i.mul) begin
      prod_w_d = ProdW'(sum_w_q) * ProdW'(bcnt_i);
      prod_b_d = ProdW'(sum_b_q) * ProdW'(wcnt_i);
    end
    if (ctrl_i.load) begin
      rem_d = NumW'(prod_w_q) + NumW'(prod_b_q);
      quo_d = '0;
    end else if (ctrl_i.div_step) begin
      if (rem_ge) begin
        rem_d = rem_q - den_ext;
      end
      quo_d = {quo_q[AdcBits-2:0], rem_ge};
    end
    if (ctrl_i.commit) begin
      level_d = quo_q;
      sum_w_d = '0;
      sum_b_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_w_q <= '0;
      sum_b_q <= '0;
      level_q <= '0;
    end else begin
      sum_w_q <= sum_w_d;
      sum_b_q <= sum_b_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_w_q <= prod_w_d;
    prod_b_q <= prod_b_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
  end

  assign dark_o  = (sample_i > level_q);
  assign level_o = level_q;

endmodule

[hdl/lsc_merge.sv]
// Merge stage: dark mask, stop latch, calibration flag and the result register.
module lsc_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [2:0]                                  cfg_wdata_i,
  input  lsc_pkg::merge_ctrl_t                        ctrl_i,
  input  logic [lsc_pkg::NumCh-1:0]                   dark_i,
  input  logic [lsc_pkg::NumCh-1:0][lsc_pkg::AdcBits-1:0] level_i,
  input  logic                                        out_ready_i,
  output logic                                        out_valid_o,
  output lsc_pkg::out_item_t                          out_item_o
);
  import lsc_pkg::*;

  function automatic logic [DarkCntW-1:0] popcount(input logic [NumCh-1:0] m);
    logic [DarkCntW-1:0] n;
    n = '0;
    for (int i = 0; i < NumCh; i++) begin
      n = n + DarkCntW'(m[i]);
    end
    return n;
  endfunction

  logic [NumCh-1:0] dark_q, dark_d;
  logic             latch_q, latch_d;
  logic             cal_q, cal_d;
  logic [2:0]       min_q, min_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic [NumCh-1:0] mask_new;

  // Before calibration a detect keeps the old mask but still checks the latch.
  assign mask_new = cal_q ? dark_i : dark_q;

  always_comb begin
    dark_d      = dark_q;
    latch_d     = latch_q;
    cal_d       = cal_q;
    min_d       = cfg_we_i ? cfg_wdata_i : min_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (ctrl_i.detect) begin
      dark_d = mask_new;
      if (popcount(mask_new) >= min_q) begin
        latch_d = 1'b1;
      end
    end
    if (ctrl_i.clear) begin
      latch_d = 1'b0;
    end
    if (ctrl_i.cal_set) begin
      cal_d = 1'b1;
    end
    if (ctrl_i.emit) begin
      out_valid_d         = 1'b1;
      out_d.dark_mask     = dark_q;
      out_d.dark_count    = popcount(dark_q);
      out_d.stop_flag     = latch_q;
      out_d.is_calibrated = cal_q;
      out_d.calib_error   = ctrl_i.err;
      out_d.level_ch0     = level_i[0];
      out_d.level_ch1     = level_i[1];
      out_d.level_ch2     = level_i[2];
      out_d.level_ch3     = level_i[3];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_q      <= '0;
      latch_q     <= 1'b0;
      cal_q       <= 1'b0;
      min_q       <= MinDarkReset;
      out_valid_q <= 1'b0;
    end else begin
      dark_q      <= dark_d;
      latch_q     <= latch_d;
      cal_q       <= cal_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result word written over one not yet taken");

  a_dark_needs_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dark_q != '0) |-> cal_q)
    else $error("dark mask set before calibration finished");

  a_clear_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> !latch_q)
    else $error("stop latch still set after a clear");

endmodule

[hdl/line_sensor_calibrate_and_detect.sv]
// Top level of the four-channel line sensor qualifier: sequencer, counts and lanes.
// A sample, detect or clear word passes the execute and emit states before its result is
// registered; the next word is taken only once the sequencer is back in idle.
// A finish word runs the cross-multiply and a restoring divider of one quotient bit per
// cycle in every lane, then commits the thresholds and sets the calibration flag.
// A waiting result does not hold off the next input word, only that word's own emit.
// Reset (asynchronous, active low) clears sums, counts, thresholds and flags at once.
module line_sensor_calibrate_and_detect #(
  parameter int unsigned COUNT_BITS = lsc_pkg::CountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lsc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lsc_pkg::out_item_t out_item_o
);
  import lsc_pkg::*;

  localparam int unsigned DshW     = 2 * COUNT_BITS + AdcBits;
  localparam int unsigned StepW    = $clog2(AdcBits);
  localparam logic [StepW-1:0] LastStep = StepW'(AdcBits - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_COMMIT,
    ST_EMIT
  } state_e;

  state_e                  state_q, state_d;
  in_item_t                item_q, item_d;
  logic [COUNT_BITS-1:0]   wcnt_q, wcnt_d;
  logic [COUNT_BITS-1:0]   bcnt_q, bcnt_d;
  logic [DshW-1:0]         den_sh_q, den_sh_d;
  logic [StepW-1:0]        step_q, step_d;
  logic                    err_q, err_d;
  logic [2*COUNT_BITS-1:0] cnt_prod;
  logic                    out_free;
  lane_ctrl_t              lane_ctrl;
  merge_ctrl_t             merge_ctrl;
  logic [NumCh-1:0][AdcBits-1:0] samples;
  logic [NumCh-1:0][AdcBits-1:0] levels;
  logic [NumCh-1:0]        dark;

  assign samples[0] = item_q.sample_ch0;
  assign samples[1] = item_q.sample_ch1;
  assign samples[2] = item_q.sample_ch2;
  assign samples[3] = item_q.sample_ch3;

  assign cnt_prod   = (2 * COUNT_BITS)'(wcnt_q) * (2 * COUNT_BITS)'(bcnt_q);
  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    wcnt_d     = wcnt_q;
    bcnt_d     = bcnt_q;
    den_sh_d   = den_sh_q;
    step_d     = step_q;
    err_d      = err_q;
    lane_ctrl  = '0;
    merge_ctrl = '0;
    merge_ctrl.err = err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        err_d   = 1'b0;
        state_d = ST_EMIT;
        unique case (kind_e'(item_q.kind))
          KIND_WHITE: begin
            if (wcnt_q != '1) begin
              lane_ctrl.acc_white = 1'b1;
              wcnt_d = wcnt_q + COUNT_BITS'(1);
            end
          end
          KIND_BLACK: begin
            if (bcnt_q != '1) begin
              lane_ctrl.acc_black = 1'b1;
              bcnt_d = bcnt_q + COUNT_BITS'(1);
            end
          end
          KIND_FINISH: begin
            if (wcnt_q == '0 || bcnt_q == '0) begin
              err_d = 1'b1;
            end else begin
              state_d = ST_MUL;
            end
          end
          KIND_DETECT: merge_ctrl.detect = 1'b1;
          KIND_CLEAR:  merge_ctrl.clear  = 1'b1;
          default: ;
        endcase
      end
      ST_MUL: begin
        lane_ctrl.mul = 1'b1;
        // Divisor 2*cw*cb aligned to the top quotient bit.
        den_sh_d = {cnt_prod, {AdcBits{1'b0}}};
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        lane_ctrl.load = 1'b1;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        lane_ctrl.div_step = 1'b1;
        den_sh_d = den_sh_q >> 1;
        step_d   = step_q + StepW'(1);
        if (step_q == LastStep) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        lane_ctrl.commit   = 1'b1;
        merge_ctrl.cal_set = 1'b1;
        wcnt_d  = '0;
        bcnt_d  = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          merge_ctrl.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      item_q   <= '0;
      wcnt_q   <= '0;
      bcnt_q   <= '0;
      den_sh_q <= '0;
      step_q   <= '0;
      err_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      item_q   <= item_d;
      wcnt_q   <= wcnt_d;
      bcnt_q   <= bcnt_d;
      den_sh_q <= den_sh_d;
      step_q   <= step_d;
      err_q    <= err_d;
    end
  end

  for (genvar g = 0; g < NumCh; g++) begin : g_lane
    lsc_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .sample_i(samples[g]),
      .wcnt_i  (wcnt_q),
      .bcnt_i  (bcnt_q),
      .den_sh_i(den_sh_q),
      .dark_o  (dark[g]),
      .level_o (levels[g])
    );
  end

  lsc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .ctrl_i     (merge_ctrl),
    .dark_i     (dark),
    .level_i    (levels),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

  a_div_needs_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_DIV) |-> (wcnt_q != '0 && bcnt_q != '0))
    else $error("threshold division started with a zero sample count");

  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while one is in work");

  a_white_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wcnt_q == '1) |=> (wcnt_q == '1 || wcnt_q == '0))
    else $error("white sample count wrapped past its full value");

endmodule
